[sv/qs_pkg.sv]
package qs_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS        = 14;
    localparam int ONE_I            = 1 << FRAC_BITS;
    localparam int DATA_W           = 16;
    localparam int BLEND_W          = 15;
    localparam int THR_W            = 15;
    localparam int THR_RESET        = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int FIFO_DEPTH_DEF   = 4;

    // Angle and CORDIC datapath
    localparam int ANG_W     = 34;
    localparam int ANG_SHIFT = 30 - FRAC_BITS;
    localparam int ANGLE_W   = 32;
    localparam int SINE_W    = 31;

    // Square root and divider widths
    localparam int SQ_STEPS = FRAC_BITS + 1;
    localparam int SQW      = 2 * FRAC_BITS + 3;
    localparam int DOT_W    = 2 * DATA_W + 2;
    localparam int PW       = DATA_W + SINE_W + 1;
    localparam int DVW      = PW + 1 - ANG_SHIFT;

    typedef logic signed [ANG_W-1:0]  ang_t;
    typedef logic signed [DATA_W-1:0] comp_t;
    typedef logic [BLEND_W-1:0]       frac_t;

    localparam ang_t ANG_HALF_PI = 34'sd1686629713;
    localparam ang_t ANG_PI      = 34'sd3373259426;
    localparam ang_t CORDIC_GAIN = 34'sd652032874;
    localparam ang_t Q30_ONE     = 34'sd1073741824;
    localparam frac_t ONE_F      = frac_t'(ONE_I);

    // atan(2^-i) in Q30
    localparam ang_t ATAN_TAB [32] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128,
        34'sd64,        34'sd32,        34'sd16,        34'sd8,
        34'sd4,         34'sd2,         34'sd1,         34'sd0
    };

    typedef enum logic [1:0] {
        PATH_COPY  = 2'd0,
        PATH_MID   = 2'd1,
        PATH_BLEND = 2'd2
    } path_t;

    // One classified request as it moves from front to back
    typedef struct packed {
        path_t                      path;
        comp_t [3:0]                a;
        comp_t [3:0]                b;
        frac_t                      u;
        logic signed [FRAC_BITS:0]  c;
        logic [FRAC_BITS:0]         s;
    } item_t;

endpackage

[sv/qs_in_if.sv]
interface qs_in_if;
    import qs_pkg::*;

    logic         valid;
    logic         ready;
    comp_t        a_w;
    comp_t        a_x;
    comp_t        a_y;
    comp_t        a_z;
    comp_t        b_w;
    comp_t        b_x;
    comp_t        b_y;
    comp_t        b_z;
    frac_t        blend;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                    input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                    output ready);
endinterface

[sv/qs_out_if.sv]
interface qs_out_if;
    import qs_pkg::*;

    logic         valid;
    logic         ready;
    comp_t        out_w;
    comp_t        out_x;
    comp_t        out_y;
    comp_t        out_z;
    logic [1:0]   path_taken;

    modport source (output valid, out_w, out_x, out_y, out_z, path_taken, input ready);
    modport sink   (input valid, out_w, out_x, out_y, out_z, path_taken, output ready);
endinterface

[sv/qs_cfg_if.sv]
interface qs_cfg_if;
    import qs_pkg::*;

    logic               valid;
    logic               ready;
    logic [THR_W-1:0]   small_angle_threshold;

    modport source (output valid, small_angle_threshold, input ready);
    modport sink   (input valid, small_angle_threshold, output ready);
endinterface

[sv/qs_fifo.sv]
module qs_fifo #(
    parameter int DEPTH = qs_pkg::FIFO_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qs_pkg::item_t  push_data,
    output logic           full,
    input  logic           pop,
    output qs_pkg::item_t  pop_data,
    output logic           empty
);
    import qs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/qs_front.sv]
module qs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    qs_in_if.sink                       item,
    input  logic [qs_pkg::THR_W-1:0]    thr,
    input  logic                        full,
    output logic                        push,
    output qs_pkg::item_t               push_data
);
    import qs_pkg::*;

    localparam int FL = 3 + SQ_STEPS;
    localparam logic signed [DOT_W-1:0] ONE_SQ = DOT_W'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        item_t              it;
        logic [SQW-1:0]     rem;
    } sq_t;

    logic [FL-1:0]              fv_reg;
    logic                       en_f;
    item_t                      s1_reg;
    logic signed [2*DATA_W-1:0] prod_reg [4];
    item_t                      s2_reg;
    item_t                      s2_next;
    logic signed [DOT_W-1:0]    dot_w;
    logic signed [DOT_W-1:0]    ct_w;
    logic                       copy_w;
    logic signed [2*FRAC_BITS+1:0] csq_w;
    sq_t                        sq_reg [SQ_STEPS+1];
    sq_t                        sq_next [SQ_STEPS];

    // Whole front advances unless its last request cannot enter the queue
    assign en_f       = !(fv_reg[FL-1] && full);
    assign item.ready = en_f;
    assign push       = fv_reg[FL-1] && en_f;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en_f)
        begin
            fv_reg <= {fv_reg[FL-2:0], item.valid};
        end
    end

    // Stage 1: capture and component products
    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            s1_reg.path <= PATH_BLEND;
            s1_reg.a    <= {item.a_z, item.a_y, item.a_x, item.a_w};
            s1_reg.b    <= {item.b_z, item.b_y, item.b_x, item.b_w};
            s1_reg.u    <= (item.blend > ONE_F) ? ONE_F : item.blend;
            s1_reg.c    <= '0;
            s1_reg.s    <= '0;
            prod_reg[0] <= item.a_w * item.b_w;
            prod_reg[1] <= item.a_x * item.b_x;
            prod_reg[2] <= item.a_y * item.b_y;
            prod_reg[3] <= item.a_z * item.b_z;
        end
    end

    // Stage 2: dot product, copy test, cosine truncated toward zero
    always_comb
    begin
        dot_w  = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1])
               + DOT_W'(prod_reg[2]) + DOT_W'(prod_reg[3]);
        copy_w = (dot_w >= ONE_SQ) || (dot_w <= -ONE_SQ);
        if (dot_w < 0)
        begin
            ct_w = (dot_w + DOT_W'(ONE_I - 1)) >>> FRAC_BITS;
        end
        else
        begin
            ct_w = dot_w >>> FRAC_BITS;
        end
        s2_next      = s1_reg;
        s2_next.path = copy_w ? PATH_COPY : PATH_BLEND;
        s2_next.c    = ct_w[FRAC_BITS:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: radicand 1 - c^2
    assign csq_w = s2_reg.c * s2_reg.c;

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            sq_reg[0].it  <= s2_reg;
            sq_reg[0].rem <= SQW'(ONE_SQ) - SQW'(csq_w);
        end
    end

    // Square root, one root bit per stage, most significant first
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - j;
        logic [SQW-1:0] trial;

        always_comb
        begin
            trial      = (SQW'(sq_reg[j].it.s) << (K + 1)) | (SQW'(1) << (2 * K));
            sq_next[j] = sq_reg[j];
            if (sq_reg[j].rem >= trial)
            begin
                sq_next[j].rem       = sq_reg[j].rem - trial;
                sq_next[j].it.s[K]   = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_f)
            begin
                sq_reg[j+1] <= sq_next[j];
            end
        end
    end

    // Classify against the small-angle bound
    always_comb
    begin
        push_data = sq_reg[SQ_STEPS].it;
        if (push_data.path != PATH_COPY)
        begin
            push_data.path = (push_data.s <= (FRAC_BITS + 1)'(thr)) ? PATH_MID : PATH_BLEND;
        end
    end

endmodule

[sv/qs_back.sv]
module qs_back #(
    parameter int CORDIC_STEPS = qs_pkg::CORDIC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            empty,
    input  qs_pkg::item_t   pop_data,
    output logic            pop,
    qs_out_if.source        result
);
    import qs_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int BL = 2 * N + 9 + DATA_W;

    typedef struct packed {
        item_t  it;
        ang_t   x;
        ang_t   y;
        ang_t   z;
    } rot_t;

    typedef struct packed {
        item_t  it;
        ang_t   xa;
        ang_t   ya;
        ang_t   za;
        ang_t   xb;
        ang_t   yb;
        ang_t   zb;
    } sin_t;

    typedef struct packed {
        item_t                      it;
        logic [3:0]                 neg;
        logic [3:0]                 ovf;
        logic [3:0][DVW-1:0]        rem;
        logic [3:0][DATA_W-1:0]     q;
    } div_t;

    logic [BL-1:0]          bv_reg;
    logic                   en_b;
    logic                   out_valid_reg;
    rot_t                   ang_reg [N+1];
    rot_t                   ang_next [N];
    rot_t                   entry_w;
    item_t                  th_item_reg;
    logic [ANGLE_W-1:0]     theta_reg;
    item_t                  tm_item_reg;
    logic [ANGLE_W-1:0]     ta_reg, tb_reg;
    logic [BLEND_W+ANGLE_W-1:0] pta_w, ptb_w;
    sin_t                   sin_reg [N+1];
    sin_t                   sin_next [N];
    ang_t                   fa_w, fb_w;
    item_t                  cl_item_reg;
    logic [SINE_W-1:0]      sa_reg, sb_reg;
    item_t                  pr_item_reg;
    logic signed [PW-1:0]   pa_reg [4];
    logic signed [PW-1:0]   pb_reg [4];
    item_t                  sm_item_reg;
    logic signed [PW:0]     num_reg [4];
    item_t                  ab_item_reg;
    logic [DVW-1:0]         dvd_reg [4];
    logic [3:0]             neg_reg;
    div_t                   dv_reg [DATA_W+1];
    div_t                   dv_next [DATA_W];
    comp_t                  res_w [4];
    comp_t                  out_reg [4];
    path_t                  out_path_reg;

    // Whole back advances when the output register is free or being taken
    assign en_b = !out_valid_reg || result.ready;
    assign pop  = en_b && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en_b)
        begin
            bv_reg        <= {bv_reg[BL-2:0], pop};
            out_valid_reg <= bv_reg[BL-1];
        end
    end

    // Entry: place (c, s) in the right half-plane for vectoring
    always_comb
    begin
        entry_w.it = pop_data;
        if (pop_data.c >= 0)
        begin
            entry_w.x = ang_t'(pop_data.c) <<< ANG_SHIFT;
            entry_w.y = ang_t'(pop_data.s) <<< ANG_SHIFT;
            entry_w.z = '0;
        end
        else
        begin
            entry_w.x = ang_t'(pop_data.s) <<< ANG_SHIFT;
            entry_w.y = (-ang_t'(pop_data.c)) <<< ANG_SHIFT;
            entry_w.z = ANG_HALF_PI;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            ang_reg[0] <= entry_w;
        end
    end

    // Vectoring CORDIC for theta = acos(c)
    for (genvar i = 0; i < N; i++)
    begin : g_vec
        always_comb
        begin
            ang_next[i] = ang_reg[i];
            if (ang_reg[i].y >= 0)
            begin
                ang_next[i].x = ang_reg[i].x + (ang_reg[i].y >>> i);
                ang_next[i].y = ang_reg[i].y - (ang_reg[i].x >>> i);
                ang_next[i].z = ang_reg[i].z + ATAN_TAB[i];
            end
            else
            begin
                ang_next[i].x = ang_reg[i].x - (ang_reg[i].y >>> i);
                ang_next[i].y = ang_reg[i].y + (ang_reg[i].x >>> i);
                ang_next[i].z = ang_reg[i].z - ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                ang_reg[i+1] <= ang_next[i];
            end
        end
    end

    // Clamp theta to [0, pi]
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            th_item_reg <= ang_reg[N].it;
            if (ang_reg[N].z < 0)
            begin
                theta_reg <= '0;
            end
            else if (ang_reg[N].z > ANG_PI)
            begin
                theta_reg <= ANGLE_W'(ANG_PI);
            end
            else
            begin
                theta_reg <= ANGLE_W'(ang_reg[N].z);
            end
        end
    end

    // Scaled angles (1-u)theta and u*theta
    assign pta_w = (BLEND_W+ANGLE_W)'(ONE_F - th_item_reg.u) * (BLEND_W+ANGLE_W)'(theta_reg);
    assign ptb_w = (BLEND_W+ANGLE_W)'(th_item_reg.u) * (BLEND_W+ANGLE_W)'(theta_reg);

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            tm_item_reg <= th_item_reg;
            ta_reg      <= pta_w[FRAC_BITS +: ANGLE_W];
            tb_reg      <= ptb_w[FRAC_BITS +: ANGLE_W];
        end
    end

    // Fold into the first quadrant, seed the rotation CORDICs
    always_comb
    begin
        fa_w = ang_t'(ta_reg);
        fb_w = ang_t'(tb_reg);
        if (fa_w > ANG_HALF_PI)
        begin
            fa_w = ANG_PI - fa_w;
        end
        if (fb_w > ANG_HALF_PI)
        begin
            fb_w = ANG_PI - fb_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            sin_reg[0].it <= tm_item_reg;
            sin_reg[0].xa <= CORDIC_GAIN;
            sin_reg[0].ya <= '0;
            sin_reg[0].za <= fa_w;
            sin_reg[0].xb <= CORDIC_GAIN;
            sin_reg[0].yb <= '0;
            sin_reg[0].zb <= fb_w;
        end
    end

    // Two rotation CORDICs side by side
    for (genvar i = 0; i < N; i++)
    begin : g_rot
        always_comb
        begin
            sin_next[i] = sin_reg[i];
            if (sin_reg[i].za >= 0)
            begin
                sin_next[i].xa = sin_reg[i].xa - (sin_reg[i].ya >>> i);
                sin_next[i].ya = sin_reg[i].ya + (sin_reg[i].xa >>> i);
                sin_next[i].za = sin_reg[i].za - ATAN_TAB[i];
            end
            else
            begin
                sin_next[i].xa = sin_reg[i].xa + (sin_reg[i].ya >>> i);
                sin_next[i].ya = sin_reg[i].ya - (sin_reg[i].xa >>> i);
                sin_next[i].za = sin_reg[i].za + ATAN_TAB[i];
            end
            if (sin_reg[i].zb >= 0)
            begin
                sin_next[i].xb = sin_reg[i].xb - (sin_reg[i].yb >>> i);
                sin_next[i].yb = sin_reg[i].yb + (sin_reg[i].xb >>> i);
                sin_next[i].zb = sin_reg[i].zb - ATAN_TAB[i];
            end
            else
            begin
                sin_next[i].xb = sin_reg[i].xb + (sin_reg[i].yb >>> i);
                sin_next[i].yb = sin_reg[i].yb - (sin_reg[i].xb >>> i);
                sin_next[i].zb = sin_reg[i].zb + ATAN_TAB[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                sin_reg[i+1] <= sin_next[i];
            end
        end
    end

    // Clamp sines to [0, 1.0]
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            cl_item_reg <= sin_reg[N].it;
            if (sin_reg[N].ya < 0)
            begin
                sa_reg <= '0;
            end
            else if (sin_reg[N].ya > Q30_ONE)
            begin
                sa_reg <= SINE_W'(Q30_ONE);
            end
            else
            begin
                sa_reg <= SINE_W'(sin_reg[N].ya);
            end
            if (sin_reg[N].yb < 0)
            begin
                sb_reg <= '0;
            end
            else if (sin_reg[N].yb > Q30_ONE)
            begin
                sb_reg <= SINE_W'(Q30_ONE);
            end
            else
            begin
                sb_reg <= SINE_W'(sin_reg[N].yb);
            end
        end
    end

    // Weighted components, then their sums
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            pr_item_reg <= cl_item_reg;
            sm_item_reg <= pr_item_reg;
            for (int k = 0; k < 4; k++)
            begin
                pa_reg[k]  <= PW'($signed(cl_item_reg.a[k])) * PW'($signed({1'b0, sa_reg}));
                pb_reg[k]  <= PW'($signed(cl_item_reg.b[k])) * PW'($signed({1'b0, sb_reg}));
                num_reg[k] <= (PW+1)'(pa_reg[k]) + (PW+1)'(pb_reg[k]);
            end
        end
    end

    // Magnitude, pre-shifted by the fixed part of the divisor
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            ab_item_reg <= sm_item_reg;
            for (int k = 0; k < 4; k++)
            begin
                neg_reg[k] <= num_reg[k] < 0;
                if (num_reg[k] < 0)
                begin
                    dvd_reg[k] <= DVW'((-num_reg[k]) >>> ANG_SHIFT);
                end
                else
                begin
                    dvd_reg[k] <= DVW'(num_reg[k] >>> ANG_SHIFT);
                end
            end
        end
    end

    // Overflow check: quotient does not fit the output width
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            dv_reg[0].it  <= ab_item_reg;
            dv_reg[0].neg <= neg_reg;
            dv_reg[0].q   <= '0;
            for (int k = 0; k < 4; k++)
            begin
                dv_reg[0].ovf[k] <= dvd_reg[k] >= (DVW'(ab_item_reg.s) << DATA_W);
                dv_reg[0].rem[k] <= dvd_reg[k];
            end
        end
    end

    // Restoring divide by s, one quotient bit per stage
    for (genvar j = 0; j < DATA_W; j++)
    begin : g_div
        localparam int K = DATA_W - 1 - j;
        logic [DVW-1:0] dsr;

        always_comb
        begin
            dsr        = DVW'(dv_reg[j].it.s) << K;
            dv_next[j] = dv_reg[j];
            for (int k = 0; k < 4; k++)
            begin
                if (dv_reg[j].rem[k] >= dsr)
                begin
                    dv_next[j].rem[k]    = dv_reg[j].rem[k] - dsr;
                    dv_next[j].q[k][K]   = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_b)
            begin
                dv_reg[j+1] <= dv_next[j];
            end
        end
    end

    // Result select with saturation
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            case (dv_reg[DATA_W].it.path)
                PATH_COPY:
                begin
                    res_w[k] = dv_reg[DATA_W].it.a[k];
                end
                PATH_MID:
                begin
                    res_w[k] = DATA_W'(((DATA_W+1)'($signed(dv_reg[DATA_W].it.a[k]))
                             + (DATA_W+1)'($signed(dv_reg[DATA_W].it.b[k]))) >>> 1);
                end
                default:
                begin
                    if (dv_reg[DATA_W].neg[k])
                    begin
                        if (dv_reg[DATA_W].ovf[k] || dv_reg[DATA_W].q[k][DATA_W-1])
                        begin
                            res_w[k] = {1'b1, {(DATA_W-1){1'b0}}};
                        end
                        else
                        begin
                            res_w[k] = -$signed(dv_reg[DATA_W].q[k]);
                        end
                    end
                    else if (dv_reg[DATA_W].ovf[k] || dv_reg[DATA_W].q[k][DATA_W-1])
                    begin
                        res_w[k] = {1'b0, {(DATA_W-1){1'b1}}};
                    end
                    else
                    begin
                        res_w[k] = $signed(dv_reg[DATA_W].q[k]);
                    end
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            out_path_reg <= dv_reg[DATA_W].it.path;
            for (int k = 0; k < 4; k++)
            begin
                out_reg[k] <= res_w[k];
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.out_w      = out_reg[0];
    assign result.out_x      = out_reg[1];
    assign result.out_y      = out_reg[2];
    assign result.out_z      = out_reg[3];
    assign result.path_taken = out_path_reg;

endmodule

[sv/quaternion_slerp.sv]
// Channel   Dir  Handshake        Payload
// item      in   valid / ready    a_w..a_z, b_w..b_z (Q2.14), blend (Q1.14)
// result    out  valid / ready    out_w..out_z (Q2.14), path_taken
// cfg       in   valid / ready    small_angle_threshold (Q1.14)
//
// One request per cycle sustained while results are taken; the front (dot
// product, square root one bit a stage) feeds the queue, which feeds the back
// (two CORDIC chains, 16-stage divider).
// Reset clears all valid bits, the queue and sets the threshold to 16.
// A stalled result freezes the back; the queue absorbs the front until full.
module quaternion_slerp #(
    parameter int CORDIC_STEPS = qs_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    qs_in_if.sink       item,
    qs_out_if.source    result,
    qs_cfg_if.sink      cfg
);
    import qs_pkg::*;

    logic [THR_W-1:0]   thr_reg;
    logic               push;
    logic               pop;
    logic               fifo_full;
    logic               fifo_empty;
    item_t              push_data;
    item_t              pop_data;

    // Threshold register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(THR_RESET);
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.small_angle_threshold;
        end
    end

    qs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .thr       (thr_reg),
        .full      (fifo_full),
        .push      (push),
        .push_data (push_data)
    );

    qs_fifo #(
        .DEPTH (FIFO_DEPTH_DEF)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    qs_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (fifo_empty),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

`ifndef SYNTH
    // Queue is never written while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !fifo_full)
        else $error("queue written while full");

    // Queue is never read while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_empty)
        else $error("queue read while empty");

    // A held result freezes the back, so nothing leaves the queue
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pop)
        else $error("queue popped while result stalled");
`endif

endmodule
